// ----- sv/assert_macros.svh -----
// assertion macros used by plane_leveling_rotation.sv
// expects signals named clk and rst in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define PLR_ASSERT_IMP(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define PLR_ASSERT_NXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/plr_pkg.sv -----
// types and constants for the plane leveling rotation block
// no dependencies
`default_nettype none

package plr_pkg;

  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

  typedef struct packed {
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic signed [31:0] third_x;
    logic signed [31:0] third_y;
    logic signed [31:0] third_z;
  } pts_t;

  typedef struct packed {
    logic signed [31:0] rot_00;
    logic signed [31:0] rot_01;
    logic signed [31:0] rot_02;
    logic signed [31:0] rot_10;
    logic signed [31:0] rot_11;
    logic signed [31:0] rot_12;
    logic signed [31:0] rot_20;
    logic signed [31:0] rot_21;
    logic signed [31:0] rot_22;
    logic               degenerate;
  } rot_t;

endpackage

`default_nettype wire

// ----- sv/plr_sqrt.sv -----
// pipelined integer square root, one result bit per stage, 32 stages
// floor(sqrt(rad)) of a 64-bit radicand; carries a side payload
`default_nettype none

module plr_sqrt #(
  parameter int PW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          vld,
  input  wire logic [63:0]   rad,
  input  wire logic [PW-1:0] pay,
  output logic               res_vld,
  output logic [31:0]        root,
  output logic [PW-1:0]      res_pay
);

  logic [33:0]   rem_q  [31];
  logic [63:0]   rad_q  [31];
  logic [31:0]   root_q [32];
  logic [PW-1:0] pay_q  [32];
  logic [31:0]   vld_q;

  for (genvar k = 0; k < 32; k++) begin : g_stage
    logic [33:0]   rem_p;
    logic [31:0]   root_p;
    logic [63:0]   rad_p;
    logic [PW-1:0] pay_p;
    logic          vld_p;
    logic [33:0]   cur;
    logic [33:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = rad;
      assign pay_p  = pay;
      assign vld_p  = vld;
    end else begin : g_next
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign rad_p  = rad_q[k-1];
      assign pay_p  = pay_q[k-1];
      assign vld_p  = vld_q[k-1];
    end

    assign cur   = {rem_p[31:0], rad_p[63-2*k -: 2]};
    assign trial = {root_p, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_q[k] <= {root_p[30:0], ge};
        pay_q[k]  <= pay_p;
      end
    end

    if (k < 31) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k] <= ge ? (cur - trial) : cur;
          rad_q[k] <= rad_p;
        end
      end
    end
  end

  assign res_vld = vld_q[31];
  assign root    = root_q[31];
  assign res_pay = pay_q[31];

endmodule

`default_nettype wire

// ----- sv/plr_div.sv -----
// pipelined restoring divider, one quotient bit per stage, 31 stages
// LANES numerators share one divisor; quotient must stay below 2^31
`default_nettype none

module plr_div #(
  parameter int LANES = 1,
  parameter int PW    = 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   en,
  input  wire logic                   vld,
  input  wire logic [LANES-1:0][61:0] num,
  input  wire logic [31:0]            den,
  input  wire logic [PW-1:0]          pay,
  output logic                        res_vld,
  output logic [LANES-1:0][30:0]      quo,
  output logic [PW-1:0]               res_pay
);

  logic [LANES-1:0][31:0] rem_q [30];
  logic [LANES-1:0][61:0] num_q [30];
  logic [31:0]            den_q [30];
  logic [LANES-1:0][30:0] quo_q [31];
  logic [PW-1:0]          pay_q [31];
  logic [30:0]            vld_q;

  for (genvar k = 0; k < 31; k++) begin : g_stage
    logic [LANES-1:0][31:0] rem_p;
    logic [LANES-1:0][61:0] num_p;
    logic [31:0]            den_p;
    logic [LANES-1:0][30:0] quo_p;
    logic [PW-1:0]          pay_p;
    logic                   vld_p;
    logic [LANES-1:0][31:0] rem_n;
    logic [LANES-1:0][30:0] quo_n;

    if (k == 0) begin : g_first
      for (genvar l = 0; l < LANES; l++) begin : g_init
        assign rem_p[l] = {1'b0, num[l][61:31]};
      end
      assign num_p = num;
      assign den_p = den;
      assign quo_p = '0;
      assign pay_p = pay;
      assign vld_p = vld;
    end else begin : g_next
      assign rem_p = rem_q[k-1];
      assign num_p = num_q[k-1];
      assign den_p = den_q[k-1];
      assign quo_p = quo_q[k-1];
      assign pay_p = pay_q[k-1];
      assign vld_p = vld_q[k-1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [32:0] cur;
      logic [32:0] diff;
      logic        ge;
      assign cur      = {rem_p[l], num_p[l][30-k]};
      assign diff     = cur - {1'b0, den_p};
      assign ge       = (cur >= {1'b0, den_p});
      assign rem_n[l] = ge ? diff[31:0] : cur[31:0];
      assign quo_n[l] = {quo_p[l][29:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo_q[k] <= quo_n;
        pay_q[k] <= pay_p;
      end
    end

    if (k < 30) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k] <= rem_n;
          num_q[k] <= num_p;
          den_q[k] <= den_p;
        end
      end
    end
  end

  assign res_vld = vld_q[30];
  assign quo     = quo_q[30];
  assign res_pay = pay_q[30];

endmodule

`default_nettype wire

// ----- sv/plane_leveling_rotation.sv -----
// plane leveling rotation: three points in, 3x3 rotation onto +Z out
// uses plr_pkg, plr_sqrt, plr_div and assert_macros.svh
//
// channel pts carries one beat of three Q16.16 points; channel rot returns one
// beat per point triple: the nine Q2.30 matrix entries and a degenerate flag
// (collinear points give the identity with degenerate set).
// every stage is registered and a beat can enter on every clock while the output
// is not stalled, so throughput is then one triple per cycle. from an accepted
// pts beat to rot_valid the path runs through 7 front stages (differences,
// cross products, scaling, squares), 32 square-root stages, one numerator stage,
// 31 divider stages for the unit normal, a product stage, a numerator stage,
// 31 divider stages for the quotient terms and the output register.
// the whole pipeline moves as one; when rot_valid is high and rot_stall is
// held, every stage freezes and pts_stall rises in the same cycle, so nothing
// is lost or repeated. synchronous reset clears all valid bits; data
// registers keep whatever they hold.
`default_nettype none

module plane_leveling_rotation (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          pts_valid,
  output logic               pts_stall,
  input  wire plr_pkg::pts_t pts,
  output logic               rot_valid,
  input  wire logic          rot_stall,
  output plr_pkg::rot_t      rot
);

  `include "assert_macros.svh"

  logic adv;
  assign adv       = !(rot_valid && rot_stall);
  assign pts_stall = !adv;

  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    logic [32:0] m;
    m = v[32] ? 33'(-v) : 33'(v);
    return m[31:0];
  endfunction

  logic [10:1] vld;

  // stage 1: edge vectors
  logic signed [32:0] pa [3];
  logic signed [32:0] pb [3];
  logic signed [31:0] p1 [3];
  logic signed [31:0] p2 [3];
  logic signed [31:0] p3 [3];

  assign p1[0] = pts.first_x;
  assign p1[1] = pts.first_y;
  assign p1[2] = pts.first_z;
  assign p2[0] = pts.second_x;
  assign p2[1] = pts.second_y;
  assign p2[2] = pts.second_z;
  assign p3[0] = pts.third_x;
  assign p3[1] = pts.third_y;
  assign p3[2] = pts.third_z;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pa[i] <= 33'(p3[i]) - 33'(p1[i]);
        pb[i] <= 33'(p2[i]) - 33'(p1[i]);
      end
    end
  end

  // stage 2: the six partial products as sign and magnitude
  logic [63:0] pm [3];
  logic [63:0] qm [3];
  logic        pn [3];
  logic        qn [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      pm[0] <= mag33(pa[1]) * mag33(pb[2]);
      pn[0] <= pa[1][32] ^ pb[2][32];
      qm[0] <= mag33(pa[2]) * mag33(pb[1]);
      qn[0] <= !(pa[2][32] ^ pb[1][32]);
      pm[1] <= mag33(pa[2]) * mag33(pb[0]);
      pn[1] <= pa[2][32] ^ pb[0][32];
      qm[1] <= mag33(pa[0]) * mag33(pb[2]);
      qn[1] <= !(pa[0][32] ^ pb[2][32]);
      pm[2] <= mag33(pa[0]) * mag33(pb[1]);
      pn[2] <= pa[0][32] ^ pb[1][32];
      qm[2] <= mag33(pa[1]) * mag33(pb[0]);
      qn[2] <= !(pa[1][32] ^ pb[0][32]);
    end
  end

  // stage 3: exact cross product, zero is never negative
  logic [64:0] nm [3];
  logic        nn [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        if (pn[i] == qn[i]) begin
          nm[i] <= {1'b0, pm[i]} + {1'b0, qm[i]};
          nn[i] <= pn[i] && ((pm[i] | qm[i]) != 64'd0);
        end else if (pm[i] >= qm[i]) begin
          nm[i] <= {1'b0, pm[i] - qm[i]};
          nn[i] <= pn[i] && (pm[i] != qm[i]);
        end else begin
          nm[i] <= {1'b0, qm[i] - pm[i]};
          nn[i] <= qn[i];
        end
      end
    end
  end

  // stage 4: leading one of the largest magnitude, sign flip onto +z
  logic [64:0] nm4 [3];
  logic [6:0]  len4;
  logic        negx4;
  logic        negy4;
  logic        degen4;
  logic [64:0] nor_all;
  logic [6:0]  len_c;

  assign nor_all = nm[0] | nm[1] | nm[2];

  always_comb begin
    len_c = '0;
    for (int j = 0; j < 65; j++) begin
      if (nor_all[j]) begin
        len_c = 7'(j + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nm4    <= nm;
      len4   <= len_c;
      negx4  <= nn[0] ^ nn[2];
      negy4  <= nn[1] ^ nn[2];
      degen4 <= (len_c == 7'd0);
    end
  end

  // stage 5: block scaling so the largest lies in [2^30, 2^31)
  logic [30:0] m5 [3];
  logic        negx5;
  logic        negy5;
  logic        degen5;
  logic [6:0]  sh_r;
  logic [6:0]  sh_l;

  assign sh_r = len4 - 7'd31;
  assign sh_l = 7'd31 - len4;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        if (len4 > 7'd31) begin
          m5[i] <= 31'(nm4[i] >> sh_r);
        end else begin
          m5[i] <= 31'(nm4[i] << sh_l);
        end
      end
      negx5  <= negx4;
      negy5  <= negy4;
      degen5 <= degen4;
    end
  end

  // stage 6: squares
  logic [61:0] sq6 [3];
  logic [30:0] m6  [3];
  logic        negx6;
  logic        negy6;
  logic        degen6;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq6[i] <= {31'd0, m5[i]} * {31'd0, m5[i]};
      end
      m6     <= m5;
      negx6  <= negx5;
      negy6  <= negy5;
      degen6 <= degen5;
    end
  end

  // stage 7: sum of squares
  logic [63:0] s7;
  logic [95:0] pay7;

  always_ff @(posedge clk) begin
    if (adv) begin
      s7   <= {2'b00, sq6[0]} + {2'b00, sq6[1]} + {2'b00, sq6[2]};
      pay7 <= {m6[0], m6[1], m6[2], negx6, negy6, degen6};
    end
  end

  logic        sq_vld;
  logic [31:0] r_sq;
  logic [95:0] pay_sq;

  plr_sqrt #(
    .PW (96)
  ) u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .vld     (vld[7]),
    .rad     (s7),
    .pay     (pay7),
    .res_vld (sq_vld),
    .root    (r_sq),
    .res_pay (pay_sq)
  );

  // stage 8: rounded numerators m * 2^30 + r/2
  logic [2:0][61:0] num8;
  logic [31:0]      den8;
  logic [2:0]       pay8;

  always_ff @(posedge clk) begin
    if (adv) begin
      num8[0] <= {1'b0, pay_sq[95:65], 30'd0} + {31'd0, r_sq[31:1]};
      num8[1] <= {1'b0, pay_sq[64:34], 30'd0} + {31'd0, r_sq[31:1]};
      num8[2] <= {1'b0, pay_sq[33:3],  30'd0} + {31'd0, r_sq[31:1]};
      den8    <= r_sq;
      pay8    <= pay_sq[2:0];
    end
  end

  logic             d1_vld;
  logic [2:0][30:0] v_d1;
  logic [2:0]       pay_d1;

  plr_div #(
    .LANES (3),
    .PW    (3)
  ) u_div_norm (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .vld     (vld[8]),
    .num     (num8),
    .den     (den8),
    .pay     (pay8),
    .res_vld (d1_vld),
    .quo     (v_d1),
    .res_pay (pay_d1)
  );

  // stage 9: signed unit normal, 1 + c, products of the magnitudes
  logic signed [31:0] nx9;
  logic signed [31:0] ny9;
  logic signed [31:0] c9;
  logic [31:0]        dd9;
  logic [61:0]        pyy9;
  logic [61:0]        pxy9;
  logic [61:0]        pxx9;
  logic               degen9;

  always_ff @(posedge clk) begin
    if (adv) begin
      nx9    <= pay_d1[2] ? -$signed({1'b0, v_d1[0]}) : $signed({1'b0, v_d1[0]});
      ny9    <= pay_d1[1] ? -$signed({1'b0, v_d1[1]}) : $signed({1'b0, v_d1[1]});
      c9     <= $signed({1'b0, v_d1[2]});
      dd9    <= 32'(plr_pkg::ONE_Q30) + {1'b0, v_d1[2]};
      pyy9   <= {31'd0, v_d1[1]} * {31'd0, v_d1[1]};
      pxy9   <= {31'd0, v_d1[0]} * {31'd0, v_d1[1]};
      pxx9   <= {31'd0, v_d1[0]} * {31'd0, v_d1[0]};
      degen9 <= pay_d1[0];
    end
  end

  // stage 10: rounded numerators for the quotient terms
  logic [2:0][61:0] num10;
  logic [31:0]      den10;
  logic [96:0]      pay10;

  always_ff @(posedge clk) begin
    if (adv) begin
      num10[0] <= pyy9 + {31'd0, dd9[31:1]};
      num10[1] <= pxy9 + {31'd0, dd9[31:1]};
      num10[2] <= pxx9 + {31'd0, dd9[31:1]};
      den10    <= dd9;
      pay10    <= {nx9, ny9, c9, degen9};
    end
  end

  logic             d2_vld;
  logic [2:0][30:0] t_d2;
  logic [96:0]      pay_d2;

  plr_div #(
    .LANES (3),
    .PW    (97)
  ) u_div_term (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .vld     (vld[10]),
    .num     (num10),
    .den     (den10),
    .pay     (pay10),
    .res_vld (d2_vld),
    .quo     (t_d2),
    .res_pay (pay_d2)
  );

  // output stage
  logic signed [31:0] nx_o;
  logic signed [31:0] ny_o;
  logic signed [31:0] c_o;
  logic               degen_o;
  logic [32:0]        sum00;
  logic [32:0]        sum11;
  logic signed [31:0] r00;
  logic signed [31:0] r11;
  logic signed [31:0] cr;
  plr_pkg::rot_t      rot_next;

  assign nx_o    = pay_d2[96:65];
  assign ny_o    = pay_d2[64:33];
  assign c_o     = pay_d2[32:1];
  assign degen_o = pay_d2[0];
  assign sum00   = {2'b00, t_d2[0]} + {1'b0, c_o};
  assign sum11   = {2'b00, t_d2[2]} + {1'b0, c_o};
  assign r00     = (sum00 > 33'(plr_pkg::ONE_Q30)) ? plr_pkg::ONE_Q30 : sum00[31:0];
  assign r11     = (sum11 > 33'(plr_pkg::ONE_Q30)) ? plr_pkg::ONE_Q30 : sum11[31:0];
  assign cr      = (nx_o[31] != ny_o[31]) ? $signed({1'b0, t_d2[1]})
                                          : -$signed({1'b0, t_d2[1]});

  always_comb begin
    if (degen_o) begin
      rot_next        = '0;
      rot_next.rot_00 = plr_pkg::ONE_Q30;
      rot_next.rot_11 = plr_pkg::ONE_Q30;
      rot_next.rot_22 = plr_pkg::ONE_Q30;
      rot_next.degenerate = 1'b1;
    end else begin
      rot_next.rot_00 = r00;
      rot_next.rot_01 = cr;
      rot_next.rot_02 = -nx_o;
      rot_next.rot_10 = cr;
      rot_next.rot_11 = r11;
      rot_next.rot_12 = -ny_o;
      rot_next.rot_20 = nx_o;
      rot_next.rot_21 = ny_o;
      rot_next.rot_22 = c_o;
      rot_next.degenerate = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rot <= rot_next;
    end
  end

  // valid bits of the front stages, stages 8 to 10 and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      rot_valid <= 1'b0;
    end else if (adv) begin
      vld[1]    <= pts_valid;
      for (int k = 2; k <= 7; k++) begin
        vld[k] <= vld[k-1];
      end
      vld[8]    <= sq_vld;
      vld[9]    <= d1_vld;
      vld[10]   <= vld[9];
      rot_valid <= d2_vld;
    end
  end

  `PLR_ASSERT_IMP(a_degen_ident, rot_valid && rot.degenerate,
    rot.rot_00 == plr_pkg::ONE_Q30 && rot.rot_01 == 32'sd0 && rot.rot_22 == plr_pkg::ONE_Q30,
    "degenerate beat is not the identity")
  `PLR_ASSERT_IMP(a_symmetry, rot_valid && !rot.degenerate,
    rot.rot_10 == rot.rot_01 && rot.rot_20 == -rot.rot_02 && rot.rot_21 == -rot.rot_12,
    "rotation entries lost their symmetry")
  `PLR_ASSERT_IMP(a_diag_range, rot_valid && !rot.degenerate,
    rot.rot_00 <= plr_pkg::ONE_Q30 && rot.rot_11 <= plr_pkg::ONE_Q30 && !rot.rot_22[31],
    "diagonal entry out of range")
  `PLR_ASSERT_NXT(a_freeze, rot_valid && rot_stall && !rst,
    rot_valid && $stable(rot_next),
    "pipeline moved while output stalled")

endmodule

`default_nettype wire
